@@ rtl/plm_mep_pkg.sv @@
// ----------------------------------------------------------------------------
// plm_mep_pkg : shared types, constants and saturating helpers
// Q16.16-style signed words held in 32 bits; the add, subtract and clamp helpers saturate.
// ----------------------------------------------------------------------------
package plm_mep_pkg;

  typedef logic signed [31:0] q_t;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // configuration register indexes
  localparam logic REG_TIME_STEP = 1'b0;
  localparam logic REG_ADIABATIC = 1'b1;

  localparam logic [18:0] ADIABATIC_RESET = 19'd109227;

  // divider operand widths
  localparam int NUM_W = 64;
  localparam int DEN_W = 35;

  // clamp a wide signed value to one word
  function automatic q_t sat32(input logic signed [63:0] x);
    q_t r;
    if (x > 64'(Q_MAX)) r = Q_MAX;
    else if (x < 64'(Q_MIN)) r = Q_MIN;
    else r = x[31:0];
    return r;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return sat32(64'(s));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    return sat32(64'(s));
  endfunction

  // three-way minmod
  function automatic q_t lim3(input q_t a, input q_t b, input q_t c);
    q_t m;
    m = '0;
    if (a > 0 && b > 0 && c > 0) begin
      m = (a < b) ? a : b;
      m = (m < c) ? m : c;
    end else if (a < 0 && b < 0 && c < 0) begin
      m = (a > b) ? a : b;
      m = (m > c) ? m : c;
    end
    return m;
  endfunction

endpackage

@@ rtl/plm_mep_div.sv @@
// ----------------------------------------------------------------------------
// plm_mep_div : iterative signed divider, one quotient bit a cycle
// Truncates toward zero, saturates to one word, gives zero for a zero divisor.
// ----------------------------------------------------------------------------
module plm_mep_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [plm_mep_pkg::NUM_W-1:0]  num,
  input  logic signed [plm_mep_pkg::DEN_W-1:0]  den,
  output logic                                  busy,
  output logic                                  done,
  output plm_mep_pkg::q_t                       res
);

  localparam int NW = plm_mep_pkg::NUM_W;
  localparam int DW = plm_mep_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dmag_r;
  logic          neg_r, zero_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   rem_sh;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r, q_r[NW-1]};
    rem_nxt = rem_sh[DW-1:0];
    q_nxt   = {q_r[NW-2:0], 1'b0};
    if (rem_sh >= {1'b0, dmag_r}) begin
      rem_nxt  = DW'(rem_sh - {1'b0, dmag_r});
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r  <= num[NW-1] ^ den[DW-1];
        zero_r <= (den == '0);
        q_r    <= num[NW-1] ? NW'(-num) : NW'(num);
        dmag_r <= den[DW-1] ? DW'(-den) : DW'(den);
        rem_r  <= '0;
        cnt_r  <= CW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // sign and saturate the magnitude
  always_comb begin
    if (zero_r) res = '0;
    else if (!neg_r) res = (|q_r[NW-1:31]) ? plm_mep_pkg::Q_MAX : q_r[31:0];
    else if ((|q_r[NW-1:32]) || (q_r[31] && (|q_r[30:0]))) res = plm_mep_pkg::Q_MIN;
    else res = 32'(-q_r[31:0]);
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

@@ rtl/plm_minmod_edge_predictor_top.sv @@
// ----------------------------------------------------------------------------
// plm_minmod_edge_predictor_top : minmod slope limiter and Hancock predictor
// Streams grid vertices and emits left and right edge states per interface.
// ----------------------------------------------------------------------------
// For an interior vertex (index 3 and up), twelve limiter slopes and one
// pressure-gradient quotient go through a shared divider at one quotient bit
// a cycle. Nineteen products go through one shared 32x32 multiplier: eleven
// once per vertex and the four relative-velocity products once per edge. The
// final interior vertex also emits an extra word. Vertices 0 and 1 are only
// taken into the window; vertex 2 emits a pass-through word, and an extra
// word when it is the final one. The input stalls while a vertex is being
// worked on; the output register lets the last word wait without holding up
// the next vertex.
module plm_minmod_edge_predictor_top #(
  parameter int FRAC_BITS    = 16,
  parameter int MAX_VERTICES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  // vertex input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_vertex_pos,
  input  logic signed [31:0] in_vertex_vel,
  input  logic [30:0]        in_cell_density,
  input  logic [30:0]        in_cell_pressure,
  input  logic signed [31:0] in_cell_vel_x,
  input  logic signed [31:0] in_cell_vel_y,
  input  logic               in_final_vertex,
  // edge state output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_interface_index,
  output logic               out_side,
  output logic signed [31:0] out_face_density,
  output logic signed [31:0] out_face_pressure,
  output logic signed [31:0] out_edge_vel_x,
  output logic signed [31:0] out_edge_vel_y,
  output logic               out_last_result,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CAP_I = (MAX_VERTICES - 1 > 65535) ? 65535 : MAX_VERTICES - 1;
  localparam logic [15:0] CAP = 16'(CAP_I);

  // sequencer codes
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PREP   = 5'd1;
  localparam logic [4:0] S_DSTART = 5'd2;
  localparam logic [4:0] S_DWAIT  = 5'd3;
  localparam logic [4:0] S_LIM    = 5'd4;
  localparam logic [4:0] S_MULA   = 5'd5;
  localparam logic [4:0] S_MULB   = 5'd6;
  localparam logic [4:0] S_QSTART = 5'd7;
  localparam logic [4:0] S_QWAIT  = 5'd8;
  localparam logic [4:0] S_REL    = 5'd9;
  localparam logic [4:0] S_COMB0  = 5'd10;
  localparam logic [4:0] S_COMB1  = 5'd11;
  localparam logic [4:0] S_COMB2  = 5'd12;
  localparam logic [4:0] S_EMSIDE = 5'd13;
  localparam logic [4:0] S_EMPASS = 5'd14;
  localparam logic [4:0] S_EMFIN  = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  // product slots
  localparam logic [3:0] M_HSU = 4'd0;
  localparam logic [3:0] M_T0  = 4'd1;
  localparam logic [3:0] M_T1  = 4'd2;
  localparam logic [3:0] M_T2  = 4'd3;
  localparam logic [3:0] M_T3  = 4'd4;
  localparam logic [3:0] M_AD  = 4'd5;
  localparam logic [3:0] M_AP  = 4'd6;
  localparam logic [3:0] M_AW  = 4'd7;
  localparam logic [3:0] M_B   = 4'd8;
  localparam logic [3:0] M_G1  = 4'd9;
  localparam logic [3:0] M_CP  = 4'd10;
  localparam logic [3:0] M_MD  = 4'd11;
  localparam logic [3:0] M_MP  = 4'd12;
  localparam logic [3:0] M_MU  = 4'd13;
  localparam logic [3:0] M_MW  = 4'd14;

  localparam int FD = 0;
  localparam int FP = 1;
  localparam int FU = 2;
  localparam int FW = 3;

  // configuration registers
  logic [30:0] ts_r;
  logic [18:0] gam_r;

  // sweep state
  logic [4:0]         state_r;
  logic [15:0]        cnt_r;
  logic               fin_r;
  plm_mep_pkg::q_t    pos_r  [4];
  plm_mep_pkg::q_t    vel_r  [3];
  plm_mep_pkg::q_t    cell_r [3][4];
  plm_mep_pkg::q_t    newc_r [4];

  // work registers
  logic [1:0]         f_r, j_r;
  logic [3:0]         m_r;
  logic               sd_r;
  logic signed [34:0] dl_r, dr_r, ds_r;
  plm_mep_pkg::q_t    hdx_r, sl0_r, sl1_r, rel_r;
  plm_mep_pkg::q_t    s_r  [4];
  plm_mep_pkg::q_t    t_r  [4];
  plm_mep_pkg::q_t    mt_r [4];
  plm_mep_pkg::q_t    e_r  [4];
  plm_mep_pkg::q_t    hsu_r, ad_r, ap_r, aw_r, b_r, g1_r, cp_r, du_r;
  logic signed [63:0] prod_r;

  // output register
  logic               ov_r;
  logic [15:0]        oidx_r;
  logic               oside_r, olast_r;
  plm_mep_pkg::q_t    oe_r [4];

  // divider link
  logic                                 div_start, div_busy, div_done;
  logic signed [plm_mep_pkg::NUM_W-1:0] div_num;
  logic signed [plm_mep_pkg::DEN_W-1:0] div_den;
  plm_mep_pkg::q_t                      div_res;

  // combinational helpers
  plm_mep_pkg::q_t    ca, cc, cb, diff, ma, mb, mres, hdt, gq;
  logic signed [32:0] hd33;
  logic               in_acc, out_free, load_out;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;
  assign load_out = out_free &&
                    (state_r == S_EMSIDE || state_r == S_EMPASS || state_r == S_EMFIN);

  assign hdt  = {2'b00, ts_r[30:1]};
  assign gq   = {13'd0, gam_r};
  assign hd33 = 33'(pos_r[2]) - 33'(pos_r[1]);

  // limiter operands for the current field
  always_comb begin
    ca = cell_r[0][f_r];
    cc = cell_r[1][f_r];
    cb = cell_r[2][f_r];
    case (j_r)
      2'd0:    diff = plm_mep_pkg::qsub(cc, ca);
      2'd1:    diff = plm_mep_pkg::qsub(cb, cc);
      default: diff = plm_mep_pkg::qsub(cb, ca);
    endcase
  end

  // divider operands: slope or pressure-gradient quotient
  always_comb begin
    if (state_r == S_QSTART) begin
      div_num = 64'(ap_r) <<< FRAC_BITS;
      div_den = 35'(cell_r[1][FD]);
    end else begin
      div_num = 64'(diff) <<< (FRAC_BITS + 1);
      case (j_r)
        2'd0:    div_den = dl_r;
        2'd1:    div_den = dr_r;
        default: div_den = ds_r;
      endcase
    end
  end
  assign div_start = (state_r == S_DSTART) || (state_r == S_QSTART);

  // multiplier operand selection
  always_comb begin
    case (m_r)
      M_HSU:   begin ma = hdt;   mb = s_r[FU];          end
      M_T0:    begin ma = hdx_r; mb = s_r[0];           end
      M_T1:    begin ma = hdx_r; mb = s_r[1];           end
      M_T2:    begin ma = hdx_r; mb = s_r[2];           end
      M_T3:    begin ma = hdx_r; mb = s_r[3];           end
      M_AD:    begin ma = hdt;   mb = s_r[FD];          end
      M_AP:    begin ma = hdt;   mb = s_r[FP];          end
      M_AW:    begin ma = hdt;   mb = s_r[FW];          end
      M_B:     begin ma = hsu_r; mb = cell_r[1][FD];    end
      M_G1:    begin ma = hsu_r; mb = gq;               end
      M_CP:    begin ma = g1_r;  mb = cell_r[1][FP];    end
      M_MD:    begin ma = ad_r;  mb = rel_r;            end
      M_MP:    begin ma = ap_r;  mb = rel_r;            end
      M_MU:    begin ma = hsu_r; mb = rel_r;            end
      default: begin ma = aw_r;  mb = rel_r;            end
    endcase
  end
  assign mres = plm_mep_pkg::sat32(prod_r >>> FRAC_BITS);

  plm_mep_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .res   (div_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r  <= '0;
      gam_r <= plm_mep_pkg::ADIABATIC_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == plm_mep_pkg::REG_TIME_STEP) ts_r <= pwdata[30:0];
      else gam_r <= pwdata[18:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == plm_mep_pkg::REG_ADIABATIC) ? {13'd0, gam_r} : {1'b0, ts_r};

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pos_r[0]  <= pos_r[1];
            pos_r[1]  <= pos_r[2];
            pos_r[2]  <= pos_r[3];
            pos_r[3]  <= in_vertex_pos;
            vel_r[0]  <= vel_r[1];
            vel_r[1]  <= vel_r[2];
            vel_r[2]  <= in_vertex_vel;
            newc_r[FD] <= {1'b0, in_cell_density};
            newc_r[FP] <= {1'b0, in_cell_pressure};
            newc_r[FU] <= in_cell_vel_x;
            newc_r[FW] <= in_cell_vel_y;
            fin_r     <= in_final_vertex;
            if (cnt_r >= 16'd3) state_r <= S_PREP;
            else if (cnt_r == 16'd2) state_r <= S_EMPASS;
            else state_r <= S_DONE;
          end
        end
        // doubled centre distances and half cell width
        S_PREP: begin
          dl_r  <= 35'(pos_r[2]) - 35'(pos_r[0]);
          dr_r  <= 35'(pos_r[3]) - 35'(pos_r[1]);
          ds_r  <= 35'(pos_r[3]) + 35'(pos_r[2]) - 35'(pos_r[1]) - 35'(pos_r[0]);
          hdx_r <= plm_mep_pkg::sat32(64'(hd33)) >>> 1;
          f_r   <= '0;
          j_r   <= '0;
          state_r <= S_DSTART;
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            case (j_r)
              2'd0:    sl0_r <= div_res;
              2'd1:    sl1_r <= div_res;
              default: ;
            endcase
            if (j_r == 2'd2) begin
              s_r[f_r] <= plm_mep_pkg::lim3(sl0_r, sl1_r,
                            plm_mep_pkg::sat32(64'(div_res) <<< 1));
              state_r  <= S_LIM;
            end else begin
              j_r     <= j_r + 2'd1;
              state_r <= S_DSTART;
            end
          end
        end
        // next field, or on to the products
        S_LIM: begin
          j_r <= '0;
          if (f_r == 2'd3) begin
            m_r     <= M_HSU;
            state_r <= S_MULA;
          end else begin
            f_r     <= f_r + 2'd1;
            state_r <= S_DSTART;
          end
        end
        S_MULA: begin
          prod_r  <= ma * mb;
          state_r <= S_MULB;
        end
        S_MULB: begin
          case (m_r)
            M_HSU:   hsu_r   <= mres;
            M_T0:    t_r[0]  <= mres;
            M_T1:    t_r[1]  <= mres;
            M_T2:    t_r[2]  <= mres;
            M_T3:    t_r[3]  <= mres;
            M_AD:    ad_r    <= mres;
            M_AP:    ap_r    <= mres;
            M_AW:    aw_r    <= mres;
            M_B:     b_r     <= mres;
            M_G1:    g1_r    <= mres;
            M_CP:    cp_r    <= mres;
            M_MD:    mt_r[0] <= mres;
            M_MP:    mt_r[1] <= mres;
            M_MU:    mt_r[2] <= mres;
            default: mt_r[3] <= mres;
          endcase
          if (m_r == M_CP) state_r <= S_QSTART;
          else if (m_r == M_MW) state_r <= S_COMB0;
          else begin
            m_r     <= m_r + 4'd1;
            state_r <= S_MULA;
          end
        end
        S_QSTART: state_r <= S_QWAIT;
        S_QWAIT: begin
          if (div_done) begin
            du_r    <= div_res;
            sd_r    <= 1'b0;
            state_r <= S_REL;
          end
        end
        // velocity relative to the edge's vertex
        S_REL: begin
          rel_r   <= plm_mep_pkg::qsub(cell_r[1][FU], sd_r ? vel_r[1] : vel_r[0]);
          m_r     <= M_MD;
          state_r <= S_MULA;
        end
        // spatial step: minus for the left edge, plus for the right edge
        S_COMB0: begin
          for (int i = 0; i < 4; i++) begin
            e_r[i] <= sd_r ? plm_mep_pkg::qadd(cell_r[1][i], t_r[i])
                           : plm_mep_pkg::qsub(cell_r[1][i], t_r[i]);
          end
          state_r <= S_COMB1;
        end
        S_COMB1: begin
          e_r[FD] <= plm_mep_pkg::qsub(e_r[FD], mt_r[0]);
          e_r[FP] <= plm_mep_pkg::qsub(e_r[FP], cp_r);
          e_r[FU] <= plm_mep_pkg::qsub(e_r[FU], mt_r[2]);
          e_r[FW] <= plm_mep_pkg::qsub(e_r[FW], mt_r[3]);
          state_r <= S_COMB2;
        end
        S_COMB2: begin
          e_r[FD] <= plm_mep_pkg::qsub(e_r[FD], b_r);
          e_r[FP] <= plm_mep_pkg::qsub(e_r[FP], mt_r[1]);
          e_r[FU] <= plm_mep_pkg::qsub(e_r[FU], du_r);
          state_r <= S_EMSIDE;
        end
        S_EMSIDE: begin
          if (out_free) begin
            if (!sd_r) begin
              sd_r    <= 1'b1;
              state_r <= S_REL;
            end else begin
              state_r <= fin_r ? S_EMFIN : S_DONE;
            end
          end
        end
        S_EMPASS: begin
          if (out_free) state_r <= fin_r ? S_EMFIN : S_DONE;
        end
        S_EMFIN: begin
          if (out_free) state_r <= S_DONE;
        end
        // advance the window or close the sweep
        S_DONE: begin
          if (fin_r) begin
            cnt_r <= '0;
          end else begin
            cell_r[0] <= cell_r[1];
            cell_r[1] <= cell_r[2];
            cell_r[2] <= newc_r;
            if (cnt_r < CAP) cnt_r <= cnt_r + 16'd1;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load_out) begin
      ov_r <= 1'b1;
      case (state_r)
        S_EMSIDE: begin
          oidx_r  <= sd_r ? cnt_r - 16'd1 : cnt_r - 16'd2;
          oside_r <= !sd_r;
          olast_r <= 1'b0;
          oe_r    <= e_r;
        end
        S_EMPASS: begin
          oidx_r  <= 16'd1;
          oside_r <= 1'b0;
          olast_r <= 1'b0;
          oe_r    <= cell_r[1];
        end
        default: begin
          oidx_r  <= cnt_r - 16'd1;
          oside_r <= 1'b1;
          olast_r <= 1'b1;
          oe_r    <= cell_r[2];
        end
      endcase
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  assign out_valid           = ov_r;
  assign out_interface_index = oidx_r;
  assign out_side            = oside_r;
  assign out_face_density    = oe_r[FD];
  assign out_face_pressure   = oe_r[FP];
  assign out_edge_vel_x      = oe_r[FU];
  assign out_edge_vel_y      = oe_r[FW];
  assign out_last_result     = olast_r;

  // checks
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |-> !load_out)
    else $error("output word overwritten while stalled");

  a_last_side: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && olast_r) |-> oside_r)
    else $error("last word not a right-side edge");

endmodule
